### hdl/crtp_pkg.sv
`timescale 1ns / 1ps

package crtp_pkg;

    localparam int COORD_BITS      = 32;
    localparam int LINE_BITS       = 16;
    localparam int MAX_FRAC_DIGITS = 9;
    localparam int RAD_BITS        = 32;
    localparam int IDX_BITS        = 16;
    localparam int FRAC_BITS       = $clog2(MAX_FRAC_DIGITS + 1);
    localparam int ACC_BITS        = (COORD_BITS > RAD_BITS) ? COORD_BITS : RAD_BITS;
    localparam int PROD_BITS       = ACC_BITS + 4;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
    localparam int CNT_BITS   = $clog2(FIFO_DEPTH + 1);

    // result kinds
    localparam logic [1:0] KIND_CIRCLE    = 2'd0;
    localparam logic [1:0] KIND_ERROR     = 2'd1;
    localparam logic [1:0] KIND_END_OK    = 2'd2;
    localparam logic [1:0] KIND_END_TRUNC = 2'd3;

    // error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_NAME     = 3'd1;
    localparam logic [2:0] ERR_OPEN     = 3'd2;
    localparam logic [2:0] ERR_COORD    = 3'd3;
    localparam logic [2:0] ERR_COMMA    = 3'd4;
    localparam logic [2:0] ERR_RADIUS   = 3'd5;
    localparam logic [2:0] ERR_CLOSE    = 3'd6;

    // characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_OPEN   = 8'h28;
    localparam logic [7:0] CH_CLOSE  = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'd48;
    localparam logic [7:0] CH_C      = 8'h63;
    localparam logic [2:0] NAME_LEN  = 3'd6;

    typedef struct packed {
        logic [1:0]            kind;
        logic [2:0]            error_code;
        logic [LINE_BITS-1:0]  line_number;
        logic [IDX_BITS-1:0]   circle_index;
        logic [COORD_BITS-1:0] x_value;
        logic [COORD_BITS-1:0] y_value;
        logic [RAD_BITS-1:0]   radius_mantissa;
        logic [FRAC_BITS-1:0]  radius_frac_digits;
        logic                  last_of_run;
    } t_res;

    // up to two results per byte: the parse result first, then the end mark
    typedef struct packed {
        logic p_valid;
        t_res p;
        logic e_valid;
        t_res e;
    } t_push;

    function automatic logic [7:0] name_char(input logic [2:0] pos);
        logic [7:0] ch;
        unique case (pos)
            3'd0:    ch = 8'h63; // c
            3'd1:    ch = 8'h69; // i
            3'd2:    ch = 8'h72; // r
            3'd3:    ch = 8'h63; // c
            3'd4:    ch = 8'h6C; // l
            3'd5:    ch = 8'h65; // e
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

### hdl/circle_record_text_parser_top.sv
`timescale 1ns / 1ps

// Circle record text parser. Feed the text one byte per request; lines of the
// form circle(x y, r) come out as circle results, the first fault on a line as
// an error result with its line number, and a zero byte or a byte flagged last
// closes the text with an end mark (ok or truncated) and returns the parser to
// its reset state. Rate: one byte per cycle while the result queue has room.
// A byte is held in an input register and parsed by the parser's state update
// once the queue has room; its results are queued in a four-entry result queue
// and shown at the output from there. A byte that both closes a record and
// ends the text gives two results, which drain one per cycle unless the receiver
// stalls; the input stalls only while the queue cannot take two more results.
module circle_record_text_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_byte_value,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [2:0]  o_error_code,
    output logic [15:0] o_line_number,
    output logic [15:0] o_circle_index,
    output logic [31:0] o_x_value,
    output logic [31:0] o_y_value,
    output logic [31:0] o_radius_mantissa,
    output logic [3:0]  o_radius_frac_digits,
    output logic        o_last_of_run
);

    logic            r_in_valid;
    logic [7:0]      r_in_byte;
    logic            r_in_last;
    logic            room;
    logic            step;
    logic            accept;
    logic            pop;
    crtp_pkg::t_push push;
    crtp_pkg::t_res  head;

    // parse the held byte only when the queue can take both possible results
    assign step    = r_in_valid && room;
    assign o_stall = r_in_valid && !room;
    assign accept  = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;

    // hold the request until the parser takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_byte_value;
            r_in_last <= i_last_byte;
        end
    end

    crtp_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_push  (push)
    );

    crtp_res_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_room  (room),
        .o_valid (o_valid),
        .o_head  (head)
    );

    assign o_kind               = head.kind;
    assign o_error_code         = head.error_code;
    assign o_line_number        = head.line_number;
    assign o_circle_index       = head.circle_index;
    assign o_x_value            = head.x_value;
    assign o_y_value            = head.y_value;
    assign o_radius_mantissa    = head.radius_mantissa;
    assign o_radius_frac_digits = head.radius_frac_digits;
    assign o_last_of_run        = head.last_of_run;

endmodule

### hdl/crtp_parser.sv
`timescale 1ns / 1ps

module crtp_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_byte,
    input  logic                 i_last,
    output crtp_pkg::t_push      o_push
);

    localparam logic [3:0] PH_IDLE       = 4'd0;
    localparam logic [3:0] PH_NAME       = 4'd1;
    localparam logic [3:0] PH_AFTER_NAME = 4'd2;
    localparam logic [3:0] PH_BX         = 4'd3;
    localparam logic [3:0] PH_XS         = 4'd4;
    localparam logic [3:0] PH_XD         = 4'd5;
    localparam logic [3:0] PH_BY         = 4'd6;
    localparam logic [3:0] PH_YS         = 4'd7;
    localparam logic [3:0] PH_YD         = 4'd8;
    localparam logic [3:0] PH_AFTER_Y    = 4'd9;
    localparam logic [3:0] PH_BR         = 4'd10;
    localparam logic [3:0] PH_RD         = 4'd11;
    localparam logic [3:0] PH_AFTER_R    = 4'd12;

    localparam int PW = crtp_pkg::PROD_BITS;
    localparam int CB = crtp_pkg::COORD_BITS;
    localparam logic [PW-1:0] COORD_CAP = PW'(1) << (CB - 1);
    localparam logic [PW-1:0] RAD_CAP   = PW'({crtp_pkg::RAD_BITS{1'b1}});
    localparam logic [CB-1:0] COORD_MAX = {1'b0, {(CB-1){1'b1}}};
    localparam logic [crtp_pkg::FRAC_BITS-1:0] FRAC_MAX =
        crtp_pkg::FRAC_BITS'(crtp_pkg::MAX_FRAC_DIGITS);

    logic [3:0]                          r_phase, n_phase;
    logic [2:0]                          r_pos, n_pos;
    logic [crtp_pkg::LINE_BITS-1:0]      r_line, n_line;
    logic [crtp_pkg::IDX_BITS-1:0]       r_rec, n_rec;
    logic [crtp_pkg::ACC_BITS-1:0]       r_acc, n_acc;
    logic                                r_neg, n_neg;
    logic [CB-1:0]                       r_x, n_x;
    logic [CB-1:0]                       r_y, n_y;
    logic [crtp_pkg::FRAC_BITS-1:0]      r_frac, n_frac;
    logic                                r_point, n_point;
    logic                                r_skip, n_skip;

    logic                                digit;
    logic [3:0]                          dval;
    logic [PW-1:0]                       prod;
    logic [crtp_pkg::ACC_BITS-1:0]       acc_coord, acc_rad;
    logic [CB-1:0]                       mag, coord;
    logic [crtp_pkg::LINE_BITS-1:0]      line_inc;
    logic [3:0]                          eff;
    logic                                fail;
    logic [2:0]                          fail_code;
    logic                                ends;
    logic                                parse;

    assign digit = (i_byte >= crtp_pkg::CH_ZERO) && (i_byte < crtp_pkg::CH_ZERO + 8'd10);
    assign dval  = digit ? 4'(i_byte - crtp_pkg::CH_ZERO) : 4'd0;

    // times ten plus digit, as shift and add
    assign prod = (PW'(r_acc) << 3) + (PW'(r_acc) << 1) + PW'(dval);
    assign acc_coord = (prod > COORD_CAP) ? crtp_pkg::ACC_BITS'(COORD_CAP)
                                          : prod[crtp_pkg::ACC_BITS-1:0];
    assign acc_rad   = (prod > RAD_CAP) ? crtp_pkg::ACC_BITS'(RAD_CAP)
                                        : prod[crtp_pkg::ACC_BITS-1:0];

    // clamp positive side, negate magnitude for negative side
    always_comb begin
        mag = r_acc[CB-1:0];
        if (!r_neg && mag > COORD_MAX) mag = COORD_MAX;
        coord = r_neg ? (~mag + CB'(1)) : mag;
    end

    assign line_inc = (r_line == {crtp_pkg::LINE_BITS{1'b1}}) ? r_line
                                                              : r_line + crtp_pkg::LINE_BITS'(1);
    assign parse = i_step && (i_byte != crtp_pkg::CH_NUL);
    assign ends  = i_step && ((i_byte == crtp_pkg::CH_NUL) || i_last);

    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_line    = r_line;
        n_rec     = r_rec;
        n_acc     = r_acc;
        n_neg     = r_neg;
        n_x       = r_x;
        n_y       = r_y;
        n_frac    = r_frac;
        n_point   = r_point;
        n_skip    = r_skip;
        fail      = 1'b0;
        fail_code = crtp_pkg::ERR_NONE;
        eff       = r_phase;
        o_push    = '0;

        if (parse && r_skip) begin
            if (i_byte == crtp_pkg::CH_NL) begin
                n_skip = 1'b0;
                n_line = line_inc;
            end
        end else if (parse) begin
            // a byte that closes a number is handled again by the next part
            if (r_phase == PH_XD && !digit) begin
                n_x = coord;
                eff = PH_BY;
            end else if (r_phase == PH_YD && !digit) begin
                n_y = coord;
                eff = PH_AFTER_Y;
            end else if (r_phase == PH_RD && !digit
                         && !(i_byte == crtp_pkg::CH_POINT && !r_point)) begin
                eff = PH_AFTER_R;
            end
            n_phase = eff;

            unique case (eff) inside
                PH_IDLE: begin
                    if (i_byte == crtp_pkg::CH_C) begin
                        n_phase = PH_NAME;
                        n_pos   = 3'd1;
                    end else if (i_byte == crtp_pkg::CH_NL) begin
                        n_line = line_inc;
                    end
                end
                PH_NAME: begin
                    if (r_pos < crtp_pkg::NAME_LEN
                            && i_byte == crtp_pkg::name_char(r_pos)) begin
                        n_pos = r_pos + 3'd1;
                        if (n_pos == crtp_pkg::NAME_LEN) n_phase = PH_AFTER_NAME;
                    end else begin
                        fail = 1'b1; fail_code = crtp_pkg::ERR_NAME;
                    end
                end
                PH_AFTER_NAME: begin
                    if (i_byte == crtp_pkg::CH_OPEN) n_phase = PH_BX;
                    else if (i_byte != crtp_pkg::CH_SPACE) begin
                        fail = 1'b1; fail_code = crtp_pkg::ERR_OPEN;
                    end
                end
                PH_BX, PH_BY: begin
                    if (i_byte == crtp_pkg::CH_MINUS) begin
                        n_neg   = 1'b1;
                        n_acc   = '0;
                        n_phase = (eff == PH_BX) ? PH_XS : PH_YS;
                    end else if (digit) begin
                        n_neg   = 1'b0;
                        n_acc   = crtp_pkg::ACC_BITS'(dval);
                        n_phase = (eff == PH_BX) ? PH_XD : PH_YD;
                    end else if (i_byte != crtp_pkg::CH_SPACE) begin
                        fail = 1'b1; fail_code = crtp_pkg::ERR_COORD;
                    end
                end
                PH_XS, PH_YS: begin
                    if (digit) begin
                        n_acc   = crtp_pkg::ACC_BITS'(dval);
                        n_phase = (eff == PH_XS) ? PH_XD : PH_YD;
                    end else begin
                        fail = 1'b1; fail_code = crtp_pkg::ERR_COORD;
                    end
                end
                PH_XD, PH_YD: begin
                    n_acc = acc_coord;
                end
                PH_AFTER_Y: begin
                    if (i_byte == crtp_pkg::CH_COMMA) n_phase = PH_BR;
                    else if (i_byte != crtp_pkg::CH_SPACE) begin
                        fail = 1'b1; fail_code = crtp_pkg::ERR_COMMA;
                    end
                end
                PH_BR: begin
                    if (digit) begin
                        n_acc   = crtp_pkg::ACC_BITS'(dval);
                        n_point = 1'b0;
                        n_frac  = '0;
                        n_phase = PH_RD;
                    end else if (i_byte != crtp_pkg::CH_SPACE) begin
                        fail = 1'b1; fail_code = crtp_pkg::ERR_RADIUS;
                    end
                end
                PH_RD: begin
                    if (!digit) begin
                        n_point = 1'b1;
                    end else if (!(r_point && r_frac >= FRAC_MAX)) begin
                        n_acc = acc_rad;
                        if (r_point) n_frac = r_frac + crtp_pkg::FRAC_BITS'(1);
                    end
                end
                PH_AFTER_R: begin
                    if (i_byte == crtp_pkg::CH_CLOSE) begin
                        o_push.p_valid              = 1'b1;
                        o_push.p.kind               = crtp_pkg::KIND_CIRCLE;
                        o_push.p.error_code         = crtp_pkg::ERR_NONE;
                        o_push.p.line_number        = r_line;
                        o_push.p.circle_index       = r_rec;
                        o_push.p.x_value            = n_x;
                        o_push.p.y_value            = n_y;
                        o_push.p.radius_mantissa    = r_acc[crtp_pkg::RAD_BITS-1:0];
                        o_push.p.radius_frac_digits = r_frac;
                        if (r_rec != {crtp_pkg::IDX_BITS{1'b1}}) begin
                            n_rec = r_rec + crtp_pkg::IDX_BITS'(1);
                        end
                        n_phase = PH_IDLE;
                        n_pos   = 3'd0;
                    end else if (i_byte != crtp_pkg::CH_SPACE) begin
                        fail = 1'b1; fail_code = crtp_pkg::ERR_CLOSE;
                    end
                end
                default: n_phase = PH_IDLE;
            endcase

            if (fail) begin
                o_push.p_valid      = 1'b1;
                o_push.p.kind       = crtp_pkg::KIND_ERROR;
                o_push.p.error_code = fail_code;
                o_push.p.line_number = r_line;
                n_phase = PH_IDLE;
                n_pos   = 3'd0;
                if (i_byte == crtp_pkg::CH_NL) n_line = line_inc;
                else n_skip = 1'b1;
            end
        end

        o_push.p.last_of_run = !ends;

        if (ends) begin
            o_push.e_valid        = 1'b1;
            o_push.e.kind         = (n_phase == PH_IDLE) ? crtp_pkg::KIND_END_OK
                                                         : crtp_pkg::KIND_END_TRUNC;
            o_push.e.error_code   = crtp_pkg::ERR_NONE;
            o_push.e.line_number  = n_line;
            o_push.e.circle_index = n_rec;
            o_push.e.last_of_run  = 1'b1;
            // end of text returns the whole parser to its reset state
            n_phase = PH_IDLE;
            n_pos   = 3'd0;
            n_line  = crtp_pkg::LINE_BITS'(1);
            n_rec   = '0;
            n_acc   = '0;
            n_neg   = 1'b0;
            n_x     = '0;
            n_y     = '0;
            n_frac  = '0;
            n_point = 1'b0;
            n_skip  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pos   <= 3'd0;
            r_line  <= crtp_pkg::LINE_BITS'(1);
            r_rec   <= '0;
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_x     <= '0;
            r_y     <= '0;
            r_frac  <= '0;
            r_point <= 1'b0;
            r_skip  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_line  <= n_line;
            r_rec   <= n_rec;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_x     <= n_x;
            r_y     <= n_y;
            r_frac  <= n_frac;
            r_point <= n_point;
            r_skip  <= n_skip;
        end
    end

    a_skip_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skip |-> (r_phase == PH_IDLE))
        else $error("skipping a line outside the idle phase");

    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ends |=> (r_line == crtp_pkg::LINE_BITS'(1)) && (r_rec == '0) && !r_skip)
        else $error("end of text did not return the parser to reset");

    a_frac_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frac <= FRAC_MAX)
        else $error("fraction digit count beyond its limit");

endmodule

### hdl/crtp_res_fifo.sv
`timescale 1ns / 1ps

module crtp_res_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  crtp_pkg::t_push  i_push,
    input  logic             i_pop,
    output logic             o_room,
    output logic             o_valid,
    output crtp_pkg::t_res   o_head
);

    localparam int PB = crtp_pkg::PTR_BITS;
    localparam int CB = crtp_pkg::CNT_BITS;

    crtp_pkg::t_res  r_mem [crtp_pkg::FIFO_DEPTH];
    logic [PB-1:0]   r_wr, r_rd;
    logic [CB-1:0]   r_cnt;
    logic [PB-1:0]   wr_e;
    logic [1:0]      n_push;

    assign o_room  = (r_cnt <= CB'(crtp_pkg::FIFO_DEPTH - 2));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];
    assign wr_e    = r_wr + PB'(i_push.p_valid);
    assign n_push  = 2'(i_push.p_valid) + 2'(i_push.e_valid);

    always_ff @(posedge i_clk) begin
        if (i_push.p_valid) r_mem[r_wr] <= i_push.p;
        if (i_push.e_valid) r_mem[wr_e] <= i_push.e;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + PB'(n_push);
            if (i_pop) r_rd <= r_rd + PB'(1);
            r_cnt <= r_cnt + CB'(n_push) - CB'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_push != 2'd0) |-> o_room)
        else $error("result pushed without room");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("result popped from an empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CB'(crtp_pkg::FIFO_DEPTH))
        else $error("result count beyond queue depth");

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the circle record text parser.
//
// A few short directed texts come first, then randomly built texts. Most
// random lines are well-formed circle records with random spacing, signs,
// boundary and overlong numbers and fraction lengths. Some are damaged by a
// stray byte, a dropped byte or a cut. A few are plain noise. Each text ends
// with a zero byte, with the last flag on its final byte, or is cut short
// somewhere in the middle. Every accepted request is run through a cycle-free
// predictor of the parser, and the results it gives are queued. The result
// checker compares each accepted result, field by field, with the oldest
// queued one.
module testbench;

    localparam int RANDOM_ITEMS   = 1850;
    localparam int IDLE_LIMIT     = 2000;
    localparam int TAIL_CYCLES    = 10;

    localparam logic [47:0] CIRCLE_WORD = "circle";
    localparam logic [63:0] COORD_CAP   = 64'h0000_0000_8000_0000;
    localparam logic [63:0] RADIUS_CAP  = 64'h0000_0000_FFFF_FFFF;

    // parser phases, as the predictor walks through a record
    typedef enum logic [3:0] {
        P_IDLE, P_NAME, P_OPEN_WAIT, P_X_START, P_X_SIGN, P_X_DIGITS,
        P_Y_START, P_Y_SIGN, P_Y_DIGITS, P_COMMA_WAIT, P_R_START, P_R_DIGITS,
        P_CLOSE_WAIT
    } t_parse_phase;

    // receiver behaviour, chosen per text
    typedef enum logic [1:0] {
        STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PATTERN
    } t_stall_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_byte_value = 8'h00;
    logic        i_last_byte = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_kind;
    logic [2:0]  o_error_code;
    logic [15:0] o_line_number;
    logic [15:0] o_circle_index;
    logic [31:0] o_x_value;
    logic [31:0] o_y_value;
    logic [31:0] o_radius_mantissa;
    logic [3:0]  o_radius_frac_digits;
    logic        o_last_of_run;

    circle_record_text_parser_top i_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_byte_value         (i_byte_value),
        .i_last_byte          (i_last_byte),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_kind               (o_kind),
        .o_error_code         (o_error_code),
        .o_line_number        (o_line_number),
        .o_circle_index       (o_circle_index),
        .o_x_value            (o_x_value),
        .o_y_value            (o_y_value),
        .o_radius_mantissa    (o_radius_mantissa),
        .o_radius_frac_digits (o_radius_frac_digits),
        .o_last_of_run        (o_last_of_run)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: a private copy of everything the parser remembers.
    // ------------------------------------------------------------------
    t_parse_phase pr_phase;
    logic [2:0]   pr_name_pos;
    logic [15:0]  pr_line;
    logic [15:0]  pr_records;
    logic [63:0]  pr_acc;
    logic         pr_negative;
    logic [31:0]  pr_x;
    logic [31:0]  pr_y;
    logic [3:0]   pr_frac;
    logic         pr_point;
    logic         pr_skip;

    crtp_pkg::t_res step_results[$];      // results of the request being predicted
    crtp_pkg::t_res expected_results[$];  // results still owed by the block

    int          fail_count = 0;
    int          results_seen = 0;
    int          items_sent = 0;
    int          burst_left = 1;
    bit          valid_driven = 1'b0;
    t_stall_mode stall_mode = STALL_NONE;
    logic [2:0]  stall_phase = 3'd0;
    int          idle_cycles = 0;

    logic [7:0]  line_q[$];
    logic [7:0]  text_q[$];
    logic        text_last_flag;

    task automatic reset_parser();
        pr_phase    = P_IDLE;
        pr_name_pos = 3'd0;
        pr_line     = 16'd1;
        pr_records  = 16'd0;
        pr_acc      = 64'd0;
        pr_negative = 1'b0;
        pr_x        = 32'd0;
        pr_y        = 32'd0;
        pr_frac     = 4'd0;
        pr_point    = 1'b0;
        pr_skip     = 1'b0;
    endtask

    task automatic advance_line();
        if (pr_line != 16'hFFFF) begin
            pr_line++;
        end
    endtask

    // Append one decimal digit; pin at the cap once it would pass it.
    function automatic logic [63:0] acc_digit(input logic [63:0] acc,
                                              input logic [63:0] d,
                                              input logic [63:0] cap);
        if (acc > (cap - d) / 10) begin
            return cap;
        end
        return acc * 10 + d;
    endfunction

    // Clamp the magnitude to the signed 32-bit range, then apply the sign.
    function automatic logic [31:0] centre_value();
        logic [63:0] mag;
        logic [63:0] neg_mag;
        mag = pr_acc;
        if (!pr_negative && mag > COORD_CAP - 1) begin
            mag = COORD_CAP - 1;
        end
        neg_mag = 64'd0 - mag;
        return pr_negative ? neg_mag[31:0] : mag[31:0];
    endfunction

    task automatic add_result(input logic [1:0] kind, input logic [2:0] code,
                              input logic [15:0] idx, input logic [31:0] x,
                              input logic [31:0] y, input logic [31:0] mant,
                              input logic [3:0] frac);
        crtp_pkg::t_res r;
        r.kind               = kind;
        r.error_code         = code;
        r.line_number        = pr_line;
        r.circle_index       = idx;
        r.x_value            = x;
        r.y_value            = y;
        r.radius_mantissa    = mant;
        r.radius_frac_digits = frac;
        r.last_of_run        = 1'b0;
        step_results.push_back(r);
    endtask

    // First fault on a line: report it and skip to the newline, unless the
    // faulty byte is that newline.
    task automatic raise_error(input logic [2:0] code, input logic [7:0] b);
        add_result(crtp_pkg::KIND_ERROR, code, 16'd0, 32'd0, 32'd0, 32'd0, 4'd0);
        pr_phase    = P_IDLE;
        pr_name_pos = 3'd0;
        if (b == crtp_pkg::CH_NL) begin
            advance_line();
        end else begin
            pr_skip = 1'b1;
        end
    endtask

    task automatic parse_char(input logic [7:0] b);
        logic        digit;
        logic [63:0] d;
        bit          again;
        digit = (b >= crtp_pkg::CH_ZERO) && (b < crtp_pkg::CH_ZERO + 8'd10);
        d     = digit ? 64'(b - crtp_pkg::CH_ZERO) : 64'd0;
        if (pr_skip) begin
            if (b == crtp_pkg::CH_NL) begin
                pr_skip = 1'b0;
                advance_line();
            end
            return;
        end
        again = 1'b1;
        while (again) begin
            again = 1'b0;
            case (pr_phase)
                P_IDLE: begin
                    if (b == crtp_pkg::CH_C) begin
                        pr_phase    = P_NAME;
                        pr_name_pos = 3'd1;
                    end else if (b == crtp_pkg::CH_NL) begin
                        advance_line();
                    end
                end
                P_NAME: begin
                    if (pr_name_pos < crtp_pkg::NAME_LEN
                            && b == CIRCLE_WORD[8 * (5 - pr_name_pos) +: 8]) begin
                        pr_name_pos++;
                        if (pr_name_pos == crtp_pkg::NAME_LEN) begin
                            pr_phase = P_OPEN_WAIT;
                        end
                    end else begin
                        raise_error(crtp_pkg::ERR_NAME, b);
                    end
                end
                P_OPEN_WAIT: begin
                    if (b == crtp_pkg::CH_OPEN) begin
                        pr_phase = P_X_START;
                    end else if (b != crtp_pkg::CH_SPACE) begin
                        raise_error(crtp_pkg::ERR_OPEN, b);
                    end
                end
                P_X_START, P_Y_START: begin
                    if (b == crtp_pkg::CH_MINUS) begin
                        pr_negative = 1'b1;
                        pr_acc      = 64'd0;
                        pr_phase    = (pr_phase == P_X_START) ? P_X_SIGN : P_Y_SIGN;
                    end else if (digit) begin
                        pr_negative = 1'b0;
                        pr_acc      = d;
                        pr_phase    = (pr_phase == P_X_START) ? P_X_DIGITS : P_Y_DIGITS;
                    end else if (b != crtp_pkg::CH_SPACE) begin
                        raise_error(crtp_pkg::ERR_COORD, b);
                    end
                end
                P_X_SIGN, P_Y_SIGN: begin
                    if (digit) begin
                        pr_acc   = d;
                        pr_phase = (pr_phase == P_X_SIGN) ? P_X_DIGITS : P_Y_DIGITS;
                    end else begin
                        raise_error(crtp_pkg::ERR_COORD, b);
                    end
                end
                P_X_DIGITS, P_Y_DIGITS: begin
                    if (digit) begin
                        pr_acc = acc_digit(pr_acc, d, COORD_CAP);
                    end else begin
                        // the byte that ends a number opens the next part
                        if (pr_phase == P_X_DIGITS) begin
                            pr_x     = centre_value();
                            pr_phase = P_Y_START;
                        end else begin
                            pr_y     = centre_value();
                            pr_phase = P_COMMA_WAIT;
                        end
                        again = 1'b1;
                    end
                end
                P_COMMA_WAIT: begin
                    if (b == crtp_pkg::CH_COMMA) begin
                        pr_phase = P_R_START;
                    end else if (b != crtp_pkg::CH_SPACE) begin
                        raise_error(crtp_pkg::ERR_COMMA, b);
                    end
                end
                P_R_START: begin
                    if (digit) begin
                        pr_acc   = d;
                        pr_point = 1'b0;
                        pr_frac  = 4'd0;
                        pr_phase = P_R_DIGITS;
                    end else if (b != crtp_pkg::CH_SPACE) begin
                        raise_error(crtp_pkg::ERR_RADIUS, b);
                    end
                end
                P_R_DIGITS: begin
                    if (digit) begin
                        // drop fraction digits past the limit
                        if (!(pr_point && pr_frac >= crtp_pkg::MAX_FRAC_DIGITS)) begin
                            pr_acc = acc_digit(pr_acc, d, RADIUS_CAP);
                            if (pr_point) begin
                                pr_frac++;
                            end
                        end
                    end else if (b == crtp_pkg::CH_POINT && !pr_point) begin
                        pr_point = 1'b1;
                    end else begin
                        pr_phase = P_CLOSE_WAIT;
                        again    = 1'b1;
                    end
                end
                P_CLOSE_WAIT: begin
                    if (b == crtp_pkg::CH_CLOSE) begin
                        add_result(crtp_pkg::KIND_CIRCLE, crtp_pkg::ERR_NONE, pr_records,
                                   pr_x, pr_y, pr_acc[31:0], pr_frac);
                        if (pr_records != 16'hFFFF) begin
                            pr_records++;
                        end
                        pr_phase    = P_IDLE;
                        pr_name_pos = 3'd0;
                    end else if (b != crtp_pkg::CH_SPACE) begin
                        raise_error(crtp_pkg::ERR_CLOSE, b);
                    end
                end
                default: pr_phase = P_IDLE;
            endcase
        end
    endtask

    // Work out every result one request causes and queue them, marking the
    // final one of the request.
    task automatic predict_byte(input logic [7:0] b, input logic last);
        crtp_pkg::t_res r;
        step_results.delete();
        if (b != crtp_pkg::CH_NUL) begin
            parse_char(b);
        end
        if (b == crtp_pkg::CH_NUL || last) begin
            add_result((pr_phase == P_IDLE) ? crtp_pkg::KIND_END_OK
                                            : crtp_pkg::KIND_END_TRUNC,
                       crtp_pkg::ERR_NONE, pr_records, 32'd0, 32'd0, 32'd0, 4'd0);
            reset_parser();
        end
        foreach (step_results[i]) begin
            r = step_results[i];
            r.last_of_run = (i == step_results.size() - 1);
            expected_results.push_back(r);
        end
    endtask

    // ------------------------------------------------------------------
    // Sender: bursts of random length, random gaps between them.
    // ------------------------------------------------------------------
    function automatic int new_burst_length();
        // now and then a long stretch with no gaps at all
        return ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                           : $urandom_range(1, 30);
    endfunction

    task automatic send_request(input logic [7:0] b, input logic last);
        i_valid      <= 1'b1;
        i_byte_value <= b;
        i_last_byte  <= last;
        valid_driven = 1'b1;
        // hold the request until an edge sees it unstalled
        do @(posedge i_clk); while (o_stall !== 1'b0);
        predict_byte(b, last);
        items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            i_valid <= 1'b0;
            valid_driven = 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = new_burst_length();
        end
    endtask

    // Drop valid and wait until the block owes nothing.
    task automatic hold_until_drained();
        if (valid_driven) begin
            i_valid <= 1'b0;
            valid_driven = 1'b0;
            @(posedge i_clk);
        end
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_string(input string s, input bit last_on_final);
        for (int i = 0; i < s.len(); i++) begin
            send_request(s[i], last_on_final && (i == s.len() - 1));
        end
    endtask

    task automatic send_text();
        foreach (text_q[i]) begin
            send_request(text_q[i], (i == text_q.size() - 1) ? text_last_flag : 1'b0);
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver stall pattern.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 3'd1;
        case (stall_mode)
            STALL_NONE:  i_stall <= 1'b0;
            STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
            default:     i_stall <= (stall_phase < 3'd5);
        endcase
    end

    // ------------------------------------------------------------------
    // Result checker.
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    task automatic check_field(input string field, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                      results_seen, field, got, want));
        end
    endtask

    always @(posedge i_clk) begin : result_check
        crtp_pkg::t_res want;
        if (i_rst_n && o_valid === 1'b1 && i_stall == 1'b0) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing owed",
                                          results_seen));
            end else begin
                want = expected_results.pop_front();
                check_field("kind", 32'(o_kind), 32'(want.kind));
                check_field("error_code", 32'(o_error_code), 32'(want.error_code));
                check_field("line_number", 32'(o_line_number), 32'(want.line_number));
                check_field("circle_index", 32'(o_circle_index), 32'(want.circle_index));
                check_field("x_value", o_x_value, want.x_value);
                check_field("y_value", o_y_value, want.y_value);
                check_field("radius_mantissa", o_radius_mantissa, want.radius_mantissa);
                check_field("radius_frac_digits", 32'(o_radius_frac_digits),
                            32'(want.radius_frac_digits));
                check_field("last_of_run", 32'(o_last_of_run), 32'(want.last_of_run));
            end
            results_seen++;
        end
    end

    // Watchdog: end the run if neither channel moves for too long.
    always @(posedge i_clk) begin
        if ((i_valid === 1'b1 && o_stall === 1'b0)
                || (o_valid === 1'b1 && i_stall === 1'b0)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Random text construction.
    // ------------------------------------------------------------------
    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++) begin
            line_q.push_back(s[i]);
        end
    endtask

    task automatic add_spaces();
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) line_q.push_back(crtp_pkg::CH_SPACE);
        end
    endtask

    // Small values mostly, with boundaries, overlong runs and leading zeros.
    function automatic string number_text();
        string s;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: s = $sformatf("%0d", $urandom_range(0, 999));
            4: s = $sformatf("%0d", $urandom);
            5: begin
                case ($urandom_range(0, 4))
                    0:       s = "2147483647";
                    1:       s = "2147483648";
                    2:       s = "2147483649";
                    3:       s = "4294967295";
                    default: s = "4294967296";
                endcase
            end
            6: begin
                s = "";
                repeat ($urandom_range(10, 14))
                    s = $sformatf("%s%0d", s, $urandom_range(0, 9));
            end
            7: s = $sformatf("00%0d", $urandom_range(0, 99));
            default: s = $sformatf("%0d", $urandom_range(0, 9));
        endcase
        return s;
    endfunction

    function automatic logic [7:0] stray_char();
        string picks;
        picks = " -.,()c\n59";
        case ($urandom_range(0, 9))
            0:          return crtp_pkg::CH_NUL;
            1, 2, 3, 4: return 8'($urandom_range(1, 255));
            default:    return picks[$urandom_range(0, picks.len() - 1)];
        endcase
    endfunction

    task automatic build_record();
        add_str("circle");
        add_spaces();
        add_str("(");
        add_spaces();
        if ($urandom_range(0, 2) == 0) begin
            add_str("-");
        end
        add_str(number_text());
        // a negative y may follow x directly; a positive one needs a space
        if ($urandom_range(0, 2) == 0) begin
            add_spaces();
            add_str("-");
        end else begin
            add_str(" ");
            add_spaces();
        end
        add_str(number_text());
        add_spaces();
        add_str(",");
        add_spaces();
        add_str(number_text());
        if ($urandom_range(0, 1) == 1) begin
            add_str(".");
            repeat (($urandom_range(0, 4) == 0) ? $urandom_range(8, 13)
                                                : $urandom_range(0, 3))
                add_str($sformatf("%0d", $urandom_range(0, 9)));
            if ($urandom_range(0, 15) == 0) begin
                add_str(".");
            end
        end
        add_spaces();
        add_str(")");
    endtask

    task automatic corrupt_line();
        int idx;
        idx = $urandom_range(0, line_q.size() - 1);
        case ($urandom_range(0, 2))
            0: line_q[idx] = stray_char();
            1: line_q.delete(idx);
            default: while (line_q.size() > idx) void'(line_q.pop_back());
        endcase
    endtask

    task automatic build_text();
        int pick;
        int cut;
        text_q.delete();
        repeat ($urandom_range(1, 5)) begin
            line_q.delete();
            pick = $urandom_range(0, 9);
            if (pick < 9) begin
                build_record();
                if (pick >= 6) begin
                    corrupt_line();
                end
                if ($urandom_range(0, 7) == 0) begin
                    build_record();
                end
            end else begin
                repeat ($urandom_range(0, 10)) line_q.push_back(8'($urandom_range(1, 255)));
            end
            foreach (line_q[i]) text_q.push_back(line_q[i]);
            text_q.push_back(crtp_pkg::CH_NL);
        end
        // close with a zero byte, flag the final newline, flag a closing
        // bracket, or cut the text anywhere
        text_last_flag = 1'b1;
        case ($urandom_range(0, 3))
            0: begin
                text_q.push_back(crtp_pkg::CH_NUL);
                text_last_flag = 1'($urandom_range(0, 1));
            end
            1: ;
            2: void'(text_q.pop_back());
            default: begin
                cut = $urandom_range(1, text_q.size());
                while (text_q.size() > cut) void'(text_q.pop_back());
            end
        endcase
        if (text_q.size() == 0) begin
            text_q.push_back(crtp_pkg::CH_NUL);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------
    // x and y with no separator, a trailing point, and a closing bracket that
    // also ends the text, so one request gives two results.
    task automatic test_adjacent_coordinates();
        stall_mode = STALL_NONE;
        send_string("circle(1-2,3.)", 1'b1);
        hold_until_drained();
    endtask

    // A name fault on a newline byte advances the line at once; a zero byte
    // then closes the text.
    task automatic test_error_on_newline();
        stall_mode = STALL_LIGHT;
        send_string("c\n", 1'b0);
        send_request(crtp_pkg::CH_NUL, 1'b0);
        hold_until_drained();
    endtask

    // Text flagged last in the middle of a name ends truncated.
    task automatic test_truncated_end();
        stall_mode = STALL_PATTERN;
        send_string("circ", 1'b1);
        hold_until_drained();
    endtask

    // Blank lines and a skipped faulty line advance the line count.
    task automatic test_line_counting();
        stall_mode = STALL_LIGHT;
        send_string("\n\ncx\ncircle(4 5,6)", 1'b0);
        send_request(crtp_pkg::CH_NUL, 1'b1);
        hold_until_drained();
    endtask

    task automatic test_random_texts();
        int start_count;
        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            build_text();
            send_text();
            if ($urandom_range(0, 7) == 0) begin
                hold_until_drained();
            end
        end
    endtask

    initial begin
        reset_parser();
        burst_left = new_burst_length();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_adjacent_coordinates();
        test_error_on_newline();
        test_truncated_end();
        test_line_counting();
        test_random_texts();

        hold_until_drained();
        // allow any stray result to surface
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
